// ----- src/pei_pkg.sv -----
// Shared constants, types and helpers for the polynomial evaluate/integrate core.
// Used by pei_div and polynomial_eval_integrate_core; depends on nothing else.
`default_nettype none

package pei_pkg;

    // Default configuration of the core.
    localparam int PEI_MAX_TERMS = 7;
    localparam int PEI_FRAC_BITS = 16;

    // Fixed data widths.
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int KDIV_W  = 3;

    // Serial divider: bits retired per cycle and resulting cycle count.
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = PROD_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Command codes carried on the input tuser.
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_INTEG = 1'b1;

    typedef struct packed {
        logic                     ov;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Clamp a 64-bit signed value to the signed 32-bit range.
    function automatic t_sat sat32(input logic signed [PROD_W-1:0] v);
        t_sat r;
        r.ov = (v[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){v[DATA_W-1]}});
        if (!r.ov) begin
            r.val = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/pei_div.sv -----
// Serial floor divider of a signed 64-bit value by a small positive integer.
// Depends on pei_pkg for widths and the status struct.
`default_nettype none

module pei_div
    import pei_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [PROD_W-1:0] i_dividend,
    input  wire logic        [KDIV_W-1:0] i_divisor,
    output t_div_stat                     o_stat,
    output logic signed      [PROD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [KDIV_W-1:0]    r_div;
    logic [KDIV_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_work;
    logic [KDIV_W-1:0]    n_rem;
    logic [PROD_W-1:0]    n_work;

    // A negative dividend q is handled as floor(q/k) = ~(~q / k), so the
    // restoring loop only ever sees a non-negative value.
    always_comb begin
        logic [KDIV_W:0] trial;
        n_rem  = r_rem;
        n_work = r_work;
        for (int j = 0; j < DIV_STEP; j++) begin
            trial  = {n_rem, n_work[PROD_W-1]};
            n_work = {n_work[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem     = KDIV_W'(trial - {1'b0, r_div});
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial[KDIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= DIV_CNT_W'(r_cnt + 1'b1);
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[PROD_W-1];
            r_work <= i_dividend[PROD_W-1] ? ~i_dividend : i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_neg ? ~r_work : r_work;

endmodule

`default_nettype wire

// ----- src/polynomial_eval_integrate_core.sv -----
// Top level of the polynomial evaluate/integrate core: config registers, sequencer,
// shared multiplier and output register. Depends on pei_pkg and pei_div.
`default_nettype none

// The core holds a polynomial of up to MAX_TERMS signed fixed-point coefficients
// (FRAC_BITS fraction bits, Q16.16 by default) written through a simple register
// port: index 0 is the term count, indexes 1 to 7 are the coefficients of x^0 to
// x^6. Each input transaction carries a command on tuser (evaluate at x_first, or
// integrate from x_first up to x_second) and both operands on tdata; each one
// produces exactly one output transaction with the saturated result on tdata and
// an overflow flag on tuser that is set when any power, difference, product or
// partial sum clipped. All work goes through one 32 by 32 signed multiplier,
// reused for every coefficient product and every power update. When integrating,
// each term past the first also waits on the serial divide by (index + 1):
// eight division steps. The input is not ready while an item is in progress;
// a finished result waits in the output register, so the next item is taken as
// soon as the sequencer is back at rest.
module polynomial_eval_integrate_core
    import pei_pkg::*;
#(
    parameter int MAX_TERMS = PEI_MAX_TERMS,
    parameter int FRAC_BITS = PEI_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [31:0] x_first, [63:32] x_second
    input  wire logic        i_s_axis_tuser,   // [0] command
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] result_value
    output logic             o_m_axis_tuser    // [0] overflow
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // Config register indexes.
    localparam logic [3:0] REG_TERM_COUNT = 4'd0;
    localparam logic [3:0] REG_COEF_FIRST = 4'd1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_QUOT = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SAT  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_PMUL = 4'd7;
    localparam logic [3:0] S_PSAT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Configuration.
    logic [KDIV_W-1:0]        r_term_count;
    logic signed [DATA_W-1:0] r_coef [MAX_TERMS];

    // Sequencer and datapath.
    logic [3:0]               r_state;
    logic                     r_cmd;
    logic [KDIV_W-1:0]        r_n;
    logic [KDIV_W-1:0]        r_i;
    logic                     r_sel;
    logic                     r_ov;
    logic signed [DATA_W-1:0] r_x1;
    logic signed [DATA_W-1:0] r_x2;
    logic signed [DATA_W-1:0] r_p1;
    logic signed [DATA_W-1:0] r_p2;
    logic signed [DATA_W-1:0] r_d;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_term;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_quot;

    // Output register.
    logic                     r_m_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_ov;

    logic signed [DATA_W-1:0] w_coef;
    logic signed [DATA_W-1:0] w_op_a;
    logic signed [DATA_W-1:0] w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [PROD_W-1:0] w_diff;
    logic [KDIV_W-1:0]        w_k;
    logic [KDIV_W-1:0]        w_n_in;
    logic                     w_need_div;
    logic                     w_last;
    logic                     w_accept;
    logic                     w_div_start;
    t_div_stat                w_div_stat;
    logic signed [PROD_W-1:0] w_div_quot;
    t_sat                     w_sat_q;
    t_sat                     w_sat_sum;
    t_sat                     w_sat_diff;
    t_sat                     w_sat_pow;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= KDIV_W'(1);
            for (int j = 0; j < MAX_TERMS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_TERM_COUNT) begin
                r_term_count <= i_cfg_wdata[KDIV_W-1:0];
            end
            for (int j = 0; j < MAX_TERMS; j++) begin
                if (i_cfg_addr == REG_COEF_FIRST + 4'(j)) begin
                    r_coef[j] <= i_cfg_wdata;
                end
            end
        end
    end

    // A term count of zero runs as one term; larger than MAX_TERMS is clipped.
    always_comb begin
        if (r_term_count == '0) begin
            w_n_in = KDIV_W'(1);
        end else if (r_term_count > KDIV_W'(MAX_TERMS)) begin
            w_n_in = KDIV_W'(MAX_TERMS);
        end else begin
            w_n_in = r_term_count;
        end
    end

    // ------------------------------------------------------------------
    // Shared datapath.
    // ------------------------------------------------------------------
    assign w_coef = r_coef[r_i[IDX_W-1:0]];

    // The one multiplier: coefficient times power (or difference) in S_MUL,
    // power times its base in S_PMUL.
    always_comb begin
        if (r_state == S_PMUL) begin
            w_op_a = r_sel ? r_p2 : r_p1;
            w_op_b = r_sel ? r_x2 : r_x1;
        end else begin
            w_op_a = w_coef;
            w_op_b = (r_cmd == CMD_INTEG) ? r_d : r_p1;
        end
    end

    assign w_prod  = w_op_a * w_op_b;
    assign w_shift = r_prod >>> FRAC_BITS;

    // Divisor is index + 1; only integration terms past the first need it.
    assign w_k        = KDIV_W'(r_i + 1'b1);
    assign w_need_div = (r_cmd == CMD_INTEG) && (r_i != '0);
    assign w_last     = ({1'b0, r_i} + 1'b1) >= {1'b0, r_n};

    assign w_sum  = {{(PROD_W-DATA_W){r_acc[DATA_W-1]}}, r_acc}
                  + {{(PROD_W-DATA_W){r_term[DATA_W-1]}}, r_term};
    assign w_diff = {{(PROD_W-DATA_W){r_p2[DATA_W-1]}}, r_p2}
                  - {{(PROD_W-DATA_W){r_p1[DATA_W-1]}}, r_p1};

    assign w_sat_q    = sat32(r_quot);
    assign w_sat_sum  = sat32(w_sum);
    assign w_sat_diff = sat32(w_diff);
    assign w_sat_pow  = sat32(w_shift);

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_div_start = (r_state == S_QUOT) && w_need_div;

    pei_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_shift),
        .i_divisor  (w_k),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded instead of emptied.
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_axis_tuser == CMD_INTEG) begin
                            r_state <= S_DIFF;
                        end else if (w_n_in == KDIV_W'(1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DIFF: r_state <= S_MUL;
                S_MUL:  r_state <= S_QUOT;
                S_QUOT: r_state <= w_need_div ? S_DIV : S_SAT;
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: r_state <= S_ACC;
                S_ACC:  r_state <= w_last ? S_DONE : S_PMUL;
                S_PMUL: r_state <= S_PSAT;
                S_PSAT: begin
                    if ((r_cmd == CMD_INTEG) && !r_sel) begin
                        r_state <= S_PMUL;
                    end else begin
                        r_state <= (r_cmd == CMD_INTEG) ? S_DIFF : S_MUL;
                    end
                end
                S_DONE: begin
                    // Hold here while the previous result is still unclaimed.
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd <= i_s_axis_tuser;
                    r_n   <= w_n_in;
                    r_x1  <= i_s_axis_tdata[31:0];
                    r_x2  <= i_s_axis_tdata[63:32];
                    r_p1  <= i_s_axis_tdata[31:0];
                    r_p2  <= i_s_axis_tdata[63:32];
                    r_sel <= 1'b0;
                    r_ov  <= 1'b0;
                    if (i_s_axis_tuser == CMD_INTEG) begin
                        r_acc <= '0;
                        r_i   <= '0;
                    end else begin
                        r_acc <= r_coef[0];
                        r_i   <= KDIV_W'(1);
                    end
                end
            end
            S_DIFF: begin
                r_d  <= w_sat_diff.val;
                r_ov <= r_ov | w_sat_diff.ov;
            end
            S_MUL: r_prod <= w_prod;
            S_QUOT: begin
                if (!w_need_div) begin
                    r_quot <= w_shift;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    r_quot <= w_div_quot;
                end
            end
            S_SAT: begin
                r_term <= w_sat_q.val;
                r_ov   <= r_ov | w_sat_q.ov;
            end
            S_ACC: begin
                r_acc <= w_sat_sum.val;
                r_ov  <= r_ov | w_sat_sum.ov;
            end
            S_PMUL: r_prod <= w_prod;
            S_PSAT: begin
                r_ov <= r_ov | w_sat_pow.ov;
                if (r_sel) begin
                    r_p2 <= w_sat_pow.val;
                end else begin
                    r_p1 <= w_sat_pow.val;
                end
                if ((r_cmd == CMD_INTEG) && !r_sel) begin
                    r_sel <= 1'b1;
                end else begin
                    r_sel <= 1'b0;
                    r_i   <= KDIV_W'(r_i + 1'b1);
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    r_out_value <= r_acc;
                    r_out_ov    <= r_ov;
                end
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_ov;

`ifndef SYNTH
    // The divider only runs while the sequencer waits on it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == S_DIV))
        else $error("divider busy outside its wait state");

    // A coefficient product never uses an index at or past the term count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_i < r_n))
        else $error("term index beyond term count");

    // After taking a transaction the core is busy on the following cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("request accepted twice in a row");
`endif

endmodule

`default_nettype wire
